// ===== design/aabbps_pkg.sv =====
// Shared types, constants and fixed-point helpers for the AABB player physics step core.
package aabbps_pkg;

  localparam int MAX_BOXES_DEF = 64;
  localparam int FRONT_STAGES  = 4;

  localparam logic [30:0]        GRAVITY_RST = 31'd642908;
  localparam logic signed [31:0] DEATH_RST   = -32'sd6553600;

  // configuration register indexes
  localparam logic CFG_GRAVITY = 1'b0;
  localparam logic CFG_DEATH   = 1'b1;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [30:0]        hw;
    logic [30:0]        hh;
    logic [30:0]        hd;
    logic               grounded;
    logic               dead;
  } plr_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        bw;
    logic [30:0]        bh;
    logic [30:0]        bd;
  } box_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [54:0] v);
    if (v > 55'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -55'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  // (a * t) >> 16, rounded toward negative infinity
  function automatic logic signed [37:0] mul_dt(input logic signed [31:0] a,
                                               input logic [20:0] t);
    logic signed [53:0] p;
    p = 54'(a) * 54'($signed({1'b0, t}));
    return 38'(p >>> 16);
  endfunction

endpackage

// ===== design/aabbps_front.sv =====
// Gravity and position integration stages ahead of the collision cell chain.
module aabbps_front (
  input  logic                clk,
  input  aabbps_pkg::plr_t    plr_in,
  input  logic [20:0]         dt_in,
  input  logic [30:0]         gravity,
  output aabbps_pkg::plr_t    plr_out
);
  import aabbps_pkg::*;

  plr_t               p1_r, p2_r, p3_r, p4_r;
  plr_t               p2_nxt, p4_nxt;
  logic [20:0]        dt1_r, dt2_r;
  logic signed [37:0] gx1_r, gz1_r, gg1_r, gy3_r;

  // form the step products that do not depend on each other
  always_ff @(posedge clk) begin
    p1_r  <= plr_in;
    dt1_r <= dt_in;
    gx1_r <= mul_dt(plr_in.vx, dt_in);
    gz1_r <= mul_dt(plr_in.vz, dt_in);
    gg1_r <= mul_dt($signed({1'b0, gravity}), dt_in);
  end

  // apply gravity, advance x and z
  always_comb begin
    p2_nxt = p1_r;
    if (!p1_r.dead) begin
      p2_nxt.vy = sat32(55'(p1_r.vy) - 55'(gg1_r));
      p2_nxt.px = sat32(55'(p1_r.px) + 55'(gx1_r));
      p2_nxt.pz = sat32(55'(p1_r.pz) + 55'(gz1_r));
    end
  end

  always_ff @(posedge clk) begin
    p2_r  <= p2_nxt;
    dt2_r <= dt1_r;
  end

  // vertical step uses the updated vertical velocity
  always_ff @(posedge clk) begin
    p3_r  <= p2_r;
    gy3_r <= mul_dt(p2_r.vy, dt2_r);
  end

  always_comb begin
    p4_nxt = p3_r;
    if (!p3_r.dead) begin
      p4_nxt.py = sat32(55'(p3_r.py) + 55'(gy3_r));
    end
  end

  always_ff @(posedge clk) begin
    p4_r <= p4_nxt;
  end

  assign plr_out = p4_r;

endmodule

// ===== design/aabbps_cell.sv =====
// One world box slot: holds the box and resolves the passing player against it.
module aabbps_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic              clk,
  input  logic              ld_en,
  input  logic [CW-1:0]     cnt,
  input  aabbps_pkg::box_t  ld_box,
  input  aabbps_pkg::plr_t  plr_in,
  output aabbps_pkg::plr_t  plr_out
);
  import aabbps_pkg::*;

  box_t               box_r;
  plr_t               plr_r, plr_nxt;
  logic               active, hit, ov_x, ov_y, ov_z;
  logic signed [32:0] dx, dy, dz;
  logic [32:0]        adx, ady, adz;
  logic [31:0]        sw, sh, sd;
  logic [32:0]        ox, oy, oz;

  // store the box when this slot is next in line
  always_ff @(posedge clk) begin
    if (ld_en && cnt == CW'(IDX)) begin
      box_r <= ld_box;
    end
  end

  // overlap test and push-out along the axis of least overlap; any tie pushes along z
  always_comb begin
    active = CW'(IDX) < cnt;
    dx  = 33'(plr_in.px) - 33'(box_r.cx);
    dy  = 33'(plr_in.py) - 33'(box_r.cy);
    dz  = 33'(plr_in.pz) - 33'(box_r.cz);
    adx = dx[32] ? 33'(-dx) : 33'(dx);
    ady = dy[32] ? 33'(-dy) : 33'(dy);
    adz = dz[32] ? 33'(-dz) : 33'(dz);
    sw  = 32'(plr_in.hw) + 32'(box_r.bw);
    sh  = 32'(plr_in.hh) + 32'(box_r.bh);
    sd  = 32'(plr_in.hd) + 32'(box_r.bd);
    ov_x = adx < 33'(sw);
    ov_y = ady < 33'(sh);
    ov_z = adz < 33'(sd);
    ox  = 33'(sw) - adx;
    oy  = 33'(sh) - ady;
    oz  = 33'(sd) - adz;
    hit = active && !plr_in.dead && ov_x && ov_y && ov_z;

    plr_nxt = plr_in;
    if (hit) begin
      if (ox < oy && ox < oz) begin
        plr_nxt.px = dx[32] ? sat32(55'(plr_in.px) - 55'($signed({1'b0, ox})))
                            : sat32(55'(plr_in.px) + 55'($signed({1'b0, ox})));
        plr_nxt.vx = '0;
      end else if (oy < ox && oy < oz) begin
        if (dy[32]) begin
          plr_nxt.py = sat32(55'(plr_in.py) - 55'($signed({1'b0, oy})));
        end else begin
          plr_nxt.py       = sat32(55'(plr_in.py) + 55'($signed({1'b0, oy})));
          plr_nxt.grounded = 1'b1;
        end
        plr_nxt.vy = '0;
      end else begin
        plr_nxt.pz = dz[32] ? sat32(55'(plr_in.pz) - 55'($signed({1'b0, oz})))
                            : sat32(55'(plr_in.pz) + 55'($signed({1'b0, oz})));
        plr_nxt.vz = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    plr_r <= plr_nxt;
  end

  assign plr_out = plr_r;

endmodule

// ===== design/aabb_player_physics_step_core.sv =====
// A step result shows on out_valid once it has passed the four integration stages, one cell
// per box slot (every slot, stored or not), a capture register and the output register.
// The input stays blocked from a step transfer until its result moves to the output register,
// so loads are taken only while no step is in flight. A finished result may wait in the output
// register while the next item enters.
// Reset (rst_n low, synchronous) empties the box table and restores the configuration defaults.
module aabb_player_physics_step_core #(
  parameter int MAX_BOXES = aabbps_pkg::MAX_BOXES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  input  logic [30:0]        in_half_width,
  input  logic [30:0]        in_half_height,
  input  logic [30:0]        in_half_depth,
  input  logic               in_dead_in,
  input  logic [20:0]        in_step_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_new_pos_x,
  output logic signed [31:0] out_new_pos_y,
  output logic signed [31:0] out_new_pos_z,
  output logic signed [31:0] out_new_vel_x,
  output logic signed [31:0] out_new_vel_y,
  output logic signed [31:0] out_new_vel_z,
  output logic               out_grounded,
  output logic               out_dead_out,
  output logic               out_killed
);
  import aabbps_pkg::*;

  localparam int CW   = $clog2(MAX_BOXES + 1);
  localparam int LAST = MAX_BOXES + FRONT_STAGES - 1;
  localparam int LW   = $clog2(LAST + 1) > 0 ? $clog2(LAST + 1) : 1;

  logic [30:0]        grav_r;
  logic signed [31:0] death_r;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [LW-1:0]      lat_r, lat_nxt;
  logic               busy_r, busy_nxt, pend_r, pend_nxt, outv_r, outv_nxt;
  logic               acc, step_acc, ld_en, capture, move, kill;
  plr_t               plr_in, fin_r, fin_nxt, out_r;
  logic               fkill_r, okill_r;
  box_t               ld_box;
  plr_t               chain [MAX_BOXES+1];

  assign in_ready = !busy_r;
  assign acc      = in_valid && in_ready;
  assign step_acc = acc && in_operation == OP_STEP;
  assign ld_en    = acc && in_operation == OP_LOAD && cnt_r < CW'(MAX_BOXES);
  assign capture  = busy_r && !pend_r && lat_r == LW'(LAST);
  assign move     = pend_r && (!outv_r || out_ready);

  // pack the incoming item
  always_comb begin
    plr_in.px       = in_pos_x;
    plr_in.py       = in_pos_y;
    plr_in.pz       = in_pos_z;
    plr_in.vx       = in_vel_x;
    plr_in.vy       = in_vel_y;
    plr_in.vz       = in_vel_z;
    plr_in.hw       = in_half_width;
    plr_in.hh       = in_half_height;
    plr_in.hd       = in_half_depth;
    plr_in.grounded = 1'b0;
    plr_in.dead     = in_dead_in;
    ld_box.cx       = in_pos_x;
    ld_box.cy       = in_pos_y;
    ld_box.cz       = in_pos_z;
    ld_box.bw       = in_half_width;
    ld_box.bh       = in_half_height;
    ld_box.bd       = in_half_depth;
  end

  aabbps_front u_front (
    .clk     (clk),
    .plr_in  (plr_in),
    .dt_in   (in_step_time),
    .gravity (grav_r),
    .plr_out (chain[0])
  );

  // one cell per box slot, player handed along each cycle
  for (genvar g = 0; g < MAX_BOXES; g++) begin : g_cell
    aabbps_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk     (clk),
      .ld_en   (ld_en),
      .cnt     (cnt_r),
      .ld_box  (ld_box),
      .plr_in  (chain[g]),
      .plr_out (chain[g+1])
    );
  end

  // sequence control
  always_comb begin
    cnt_nxt  = ld_en ? cnt_r + CW'(1) : cnt_r;
    lat_nxt  = lat_r;
    busy_nxt = busy_r;
    pend_nxt = pend_r;
    outv_nxt = outv_r;
    if (step_acc) begin
      busy_nxt = 1'b1;
      lat_nxt  = '0;
    end else if (busy_r && !pend_r && !capture) begin
      lat_nxt = lat_r + LW'(1);
    end
    if (capture) begin
      pend_nxt = 1'b1;
    end
    if (out_ready) begin
      outv_nxt = 1'b0;
    end
    if (move) begin
      pend_nxt = 1'b0;
      busy_nxt = 1'b0;
      outv_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      lat_r   <= '0;
      busy_r  <= 1'b0;
      pend_r  <= 1'b0;
      outv_r  <= 1'b0;
      grav_r  <= GRAVITY_RST;
      death_r <= DEATH_RST;
    end else begin
      cnt_r  <= cnt_nxt;
      lat_r  <= lat_nxt;
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      outv_r <= outv_nxt;
      if (cfg_we && cfg_index == CFG_GRAVITY) begin
        grav_r <= cfg_wdata[30:0];
      end
      if (cfg_we && cfg_index == CFG_DEATH) begin
        death_r <= cfg_wdata;
      end
    end
  end

  // death check at the end of the chain
  assign kill = !chain[MAX_BOXES].dead && chain[MAX_BOXES].py < death_r;

  always_comb begin
    fin_nxt      = chain[MAX_BOXES];
    fin_nxt.dead = chain[MAX_BOXES].dead || kill;
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      fin_r   <= fin_nxt;
      fkill_r <= kill;
    end
    if (move) begin
      out_r   <= fin_r;
      okill_r <= fkill_r;
    end
  end

  assign out_valid     = outv_r;
  assign out_new_pos_x = out_r.px;
  assign out_new_pos_y = out_r.py;
  assign out_new_pos_z = out_r.pz;
  assign out_new_vel_x = out_r.vx;
  assign out_new_vel_y = out_r.vy;
  assign out_new_vel_z = out_r.vz;
  assign out_grounded  = out_r.grounded;
  assign out_dead_out  = out_r.dead;
  assign out_killed    = okill_r;

endmodule

// ===== design/aabbps_checker.sv =====
// Port-level checks for the AABB player physics step core, bound to the top level.
module aabbps_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_operation,
  input logic out_valid,
  input logic out_ready,
  input logic out_dead_out,
  input logic out_killed
);
  import aabbps_pkg::*;

  // a step transfer blocks the input until its result is handed on
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_STEP |=> !in_ready)
    else $error("input ready right after a step transfer");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_LOAD && !out_valid |=> !out_valid)
    else $error("result appeared after a load");

  // a killed player is dead
  a_kill_dead: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_killed |-> out_dead_out)
    else $error("killed without dead");

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind aabb_player_physics_step_core aabbps_checker u_aabbps_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_operation (in_operation),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_dead_out (out_dead_out),
  .out_killed   (out_killed)
);

// ===== dv/aabb_player_physics_step_core_tb.sv =====
// Testbench for the AABB player physics step core: scoreboard against a behavioral predictor.
`timescale 1ns / 1ps

module aabb_player_physics_step_core_tb;
  import aabbps_pkg::*;

  localparam int  NBOX       = MAX_BOXES_DEF;
  localparam int  DRAIN_WAIT = MAX_BOXES_DEF + 20;
  localparam int  STALL_MAX  = 20000;
  localparam int  ONE        = 65536;
  localparam int  INT_MAX    = 32'h7fffffff;
  localparam int  INT_MIN    = 32'h80000000;
  localparam int  DT_MAX     = 1048576;

  typedef struct {
    logic        op;
    int          px, py, pz, vx, vy, vz;
    logic [30:0] hw, hh, hd;
    logic        dead;
    logic [20:0] dt;
  } item_t;

  typedef struct {
    int   px, py, pz, vx, vy, vz;
    logic grounded, dead, killed;
  } player_state_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we, cfg_index;
  logic [31:0] cfg_wdata;
  logic in_valid, in_ready, in_operation, in_dead_in;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z, in_vel_x, in_vel_y, in_vel_z;
  logic [30:0] in_half_width, in_half_height, in_half_depth;
  logic [20:0] in_step_time;
  logic out_valid, out_ready, out_grounded, out_dead_out, out_killed;
  logic signed [31:0] out_new_pos_x, out_new_pos_y, out_new_pos_z;
  logic signed [31:0] out_new_vel_x, out_new_vel_y, out_new_vel_z;

  aabb_player_physics_step_core DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state: world box table and configuration
  int     world_cx[NBOX], world_cy[NBOX], world_cz[NBOX];
  longint world_hw[NBOX], world_hh[NBOX], world_hd[NBOX];
  int     boxes_stored;
  longint gravity;
  int     death_y;

  player_state_t expected_players[$];
  player_state_t exp_p;
  int errors;
  int send_idle_pct, recv_stall_pct;
  int quiet_cycles;

  function automatic longint clamp32(input longint v);
    if (v > longint'(INT_MAX)) return longint'(INT_MAX);
    if (v < longint'(INT_MIN)) return longint'(INT_MIN);
    return v;
  endfunction

  // floor((a * t) / 2^16)
  function automatic longint scale_by_dt(input longint a, input longint t);
    return (a * t) >>> 16;
  endfunction

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  // update the box table or predict one physics step
  task automatic predict_item(input item_t it);
    longint x, y, z, vx, vy, vz, dx, dy, dz, sw, sh, sd, ox, oy, oz, dt;
    player_state_t r;
    if (it.op == OP_LOAD) begin
      if (boxes_stored < NBOX) begin
        world_cx[boxes_stored] = it.px;
        world_cy[boxes_stored] = it.py;
        world_cz[boxes_stored] = it.pz;
        world_hw[boxes_stored] = it.hw;
        world_hh[boxes_stored] = it.hh;
        world_hd[boxes_stored] = it.hd;
        boxes_stored++;
      end
      return;
    end
    x = it.px; y = it.py; z = it.pz;
    vx = it.vx; vy = it.vy; vz = it.vz;
    dt = it.dt;
    r.grounded = 1'b0;
    r.killed = 1'b0;
    r.dead = it.dead;
    if (!it.dead) begin
      vy = clamp32(vy - scale_by_dt(gravity, dt));
      x = clamp32(x + scale_by_dt(vx, dt));
      y = clamp32(y + scale_by_dt(vy, dt));
      z = clamp32(z + scale_by_dt(vz, dt));
      // resolve against each box in load order
      for (int i = 0; i < boxes_stored; i++) begin
        dx = x - world_cx[i];
        dy = y - world_cy[i];
        dz = z - world_cz[i];
        sw = longint'(it.hw) + world_hw[i];
        sh = longint'(it.hh) + world_hh[i];
        sd = longint'(it.hd) + world_hd[i];
        if (mag(dx) < sw && mag(dy) < sh && mag(dz) < sd) begin
          ox = sw - mag(dx);
          oy = sh - mag(dy);
          oz = sd - mag(dz);
          if (ox < oy && ox < oz) begin
            x = clamp32(dx < 0 ? x - ox : x + ox);
            vx = 0;
          end else if (oy < ox && oy < oz) begin
            if (dy < 0) begin
              y = clamp32(y - oy);
            end else begin
              y = clamp32(y + oy);
              r.grounded = 1'b1;
            end
            vy = 0;
          end else begin
            z = clamp32(dz < 0 ? z - oz : z + oz);
            vz = 0;
          end
        end
      end
      if (y < longint'(death_y)) begin
        r.dead = 1'b1;
        r.killed = 1'b1;
      end
    end
    r.px = int'(x); r.py = int'(y); r.pz = int'(z);
    r.vx = int'(vx); r.vy = int'(vy); r.vz = int'(vz);
    expected_players = {expected_players, r};
  endtask

  // drive one item and hold it until the transfer
  task automatic send_item(input item_t it);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= it.op;
    in_pos_x       <= it.px;
    in_pos_y       <= it.py;
    in_pos_z       <= it.pz;
    in_vel_x       <= it.vx;
    in_vel_y       <= it.vy;
    in_vel_z       <= it.vz;
    in_half_width  <= it.hw;
    in_half_height <= it.hh;
    in_half_depth  <= it.hd;
    in_dead_in     <= it.dead;
    in_step_time   <= it.dt;
    do @(posedge clk); while (!in_ready);
    predict_item(it);
  endtask

  // drop valid, wait for every result, then let the block settle
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_players.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GRAVITY) gravity = longint'(data[30:0]);
    else death_y = int'(data);
    @(posedge clk);
  endtask

  function automatic item_t make_item(input logic op, input int px, input int py,
                                      input int pz, input int vx, input int vy,
                                      input int vz, input int hw, input int hh,
                                      input int hd, input logic dead, input int dt);
    item_t it;
    it.op = op;
    it.px = px; it.py = py; it.pz = pz;
    it.vx = vx; it.vy = vy; it.vz = vz;
    it.hw = hw[30:0]; it.hh = hh[30:0]; it.hd = hd[30:0];
    it.dead = dead;
    it.dt = dt[20:0];
    return it;
  endfunction

  // mostly players placed around stored boxes, some loads, some raw noise
  function automatic item_t random_item();
    item_t it;
    int sel, idx;
    longint span;
    sel = $urandom_range(0, 99);
    span = 8 * ONE;
    if (sel < 12) begin
      it = make_item(OP_LOAD, $urandom_range(0, 32 * ONE) - 16 * ONE,
                     $urandom_range(0, 32 * ONE) - 16 * ONE,
                     $urandom_range(0, 32 * ONE) - 16 * ONE,
                     $urandom, $urandom, $urandom,
                     $urandom_range(ONE / 4, 4 * ONE), $urandom_range(ONE / 4, 4 * ONE),
                     $urandom_range(ONE / 4, 4 * ONE), $urandom_range(0, 1), $urandom);
    end else if (sel < 80 && boxes_stored > 0) begin
      idx = $urandom_range(0, boxes_stored - 1);
      it = make_item(OP_STEP,
                     int'(clamp32(world_cx[idx] + longint'($urandom_range(0, 2 * span)) - span)),
                     int'(clamp32(world_cy[idx] + longint'($urandom_range(0, 2 * span)) - span)),
                     int'(clamp32(world_cz[idx] + longint'($urandom_range(0, 2 * span)) - span)),
                     $urandom_range(0, 4 * ONE) - 2 * ONE,
                     $urandom_range(0, 4 * ONE) - 2 * ONE,
                     $urandom_range(0, 4 * ONE) - 2 * ONE,
                     $urandom_range(0, 3 * ONE), $urandom_range(0, 3 * ONE),
                     $urandom_range(0, 3 * ONE), $urandom_range(0, 99) < 5,
                     $urandom_range(0, ONE / 8));
    end else begin
      it = make_item(OP_STEP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom_range(0, 1),
                     $urandom_range(0, DT_MAX));
    end
    return it;
  endfunction

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) send_item(random_item());
  endtask

  // hand-picked pushes, ties, edges, saturation, death and dead passthrough
  task automatic test_directed_cases;
    send_idle_pct = 9;
    recv_stall_pct = 77;
    send_item(make_item(OP_STEP, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, 1'b0, ONE / 4));
    send_item(make_item(OP_LOAD, 0, 0, 0, 0, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE, 1'b0, 0));
    send_item(make_item(OP_LOAD, 10 * ONE, 0, 0, -1, -1, -1, ONE, ONE, ONE, 1'b1, DT_MAX));
    send_item(make_item(OP_LOAD, INT_MAX, INT_MIN, INT_MAX, 0, 0, 0,
                        INT_MAX, 0, INT_MAX, 1'b0, 0));
    send_item(make_item(OP_STEP, 0, 5 * ONE / 2, 0, ONE, -ONE, ONE, ONE, ONE, ONE, 1'b0, 0));
    send_item(make_item(OP_STEP, 0, -5 * ONE / 2, 0, 0, 0, 0, ONE, ONE, ONE, 1'b0, 0));
    send_item(make_item(OP_STEP, 5 * ONE / 2, 0, ONE / 3, ONE, ONE, ONE,
                        ONE, ONE, ONE, 1'b0, 0));
    send_item(make_item(OP_STEP, -5 * ONE / 2, 0, 0, ONE, 0, 0, ONE, ONE, ONE, 1'b0, 0));
    send_item(make_item(OP_STEP, 0, 0, -5 * ONE / 2, 0, 0, ONE, ONE, ONE, ONE, 1'b0, 0));
    send_item(make_item(OP_STEP, 0, 0, 0, ONE, ONE, ONE, ONE, ONE, ONE, 1'b0, 0));
    send_item(make_item(OP_STEP, 5 * ONE / 2, 5 * ONE / 2, 0, ONE, ONE, ONE,
                        ONE, ONE, ONE, 1'b0, 0));
    send_item(make_item(OP_STEP, 3 * ONE, 0, 0, 0, 0, 0, ONE, ONE, ONE, 1'b0, 0));
    send_item(make_item(OP_STEP, 0, 0, 0, INT_MAX, INT_MIN, -1,
                        INT_MAX, INT_MAX, INT_MAX, 1'b1, DT_MAX));
    send_item(make_item(OP_STEP, 50 * ONE, -200 * ONE, 0, 0, 0, 0, ONE, ONE, ONE, 1'b0, 0));
    send_item(make_item(OP_STEP, INT_MAX, INT_MAX, INT_MAX, INT_MAX, INT_MIN, INT_MAX,
                        ONE, ONE, ONE, 1'b0, DT_MAX));
    send_item(make_item(OP_STEP, INT_MIN, INT_MIN, INT_MIN, INT_MIN, INT_MAX, INT_MIN,
                        ONE, ONE, ONE, 1'b0, DT_MAX));
    send_item(make_item(OP_STEP, 0, INT_MIN, 0, 0, 0, 0, 4 * ONE, 4 * ONE, ONE, 1'b0, 0));
    send_item(make_item(OP_STEP, 0, 5 * ONE, 0, 0, 0, 0, ONE, ONE, ONE, 1'b0, ONE / 2));
    send_item(make_item(OP_STEP, 5 * ONE, ONE / 2, 0, ONE, ONE, ONE,
                        6 * ONE, ONE, ONE, 1'b0, 0));
    send_item(make_item(OP_STEP, 0, 0, 0, 0, 0, 0, INT_MAX, INT_MAX, INT_MAX, 1'b0, 0));
    send_item(make_item(OP_STEP, 10 * ONE, 2 * ONE, 0, 0, -ONE, 0, ONE, ONE, ONE, 1'b0, 0));
  endtask

  task automatic test_receiver_backpressure;
    drain();
    write_reg(CFG_GRAVITY, 32'd0);
    write_reg(CFG_DEATH, 32'h80000000);
    run_random(260);
  endtask

  task automatic test_sender_gaps;
    drain();
    send_idle_pct = 77;
    recv_stall_pct = 9;
    write_reg(CFG_GRAVITY, 32'h7fffffff);
    write_reg(CFG_DEATH, 32'h7fffffff);
    run_random(260);
  endtask

  task automatic test_full_rate;
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(CFG_GRAVITY, 32'd642252);
    write_reg(CFG_DEATH, -32'sd524288);
    run_random(260);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_players.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result pos_y=%0d", out_new_pos_y);
      end else begin
        exp_p = expected_players.pop_front();
        if (out_new_pos_x !== exp_p.px || out_new_pos_y !== exp_p.py ||
            out_new_pos_z !== exp_p.pz || out_new_vel_x !== exp_p.vx ||
            out_new_vel_y !== exp_p.vy || out_new_vel_z !== exp_p.vz ||
            out_grounded !== exp_p.grounded || out_dead_out !== exp_p.dead ||
            out_killed !== exp_p.killed) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch expected %p", exp_p);
            $display("  got pos %0d %0d %0d vel %0d %0d %0d g%b d%b k%b",
                     out_new_pos_x, out_new_pos_y, out_new_pos_z, out_new_vel_x,
                     out_new_vel_y, out_new_vel_z, out_grounded, out_dead_out,
                     out_killed);
          end
        end
      end
    end
  end

  // abort when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    quiet_cycles = 0;
    boxes_stored = 0;
    gravity = longint'(GRAVITY_RST);
    death_y = DEATH_RST;
    send_idle_pct = 9;
    recv_stall_pct = 77;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_GRAVITY;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_operation = OP_LOAD;
    {in_pos_x, in_pos_y, in_pos_z, in_vel_x, in_vel_y, in_vel_z} = '0;
    {in_half_width, in_half_height, in_half_depth} = '0;
    in_dead_in = 1'b0;
    in_step_time = '0;
    out_ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_receiver_backpressure();
    test_sender_gaps();
    test_full_rate();
    drain();
    if (errors == 0 && expected_players.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
